/* src/cle_pkg.sv */
package cle_pkg;

  localparam int MAX_PAIRS  = 8;
  localparam int POS_W      = 14;  // signed frame coordinates, band may lie off frame
  localparam int SUM_W      = 26;  // region sum and white limit
  localparam int CNT_W      = 18;  // nominal pixel count of one region
  localparam int ACC_W      = 18;  // signed weighted pair sum
  localparam int MAG_W      = 17;  // magnitude of the weighted sum
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH     = 3'd0,
    REG_FRAME_HEIGHT    = 3'd1,
    REG_BAND_WIDTH      = 3'd2,
    REG_BAND_HEIGHT     = 3'd3,
    REG_BOTTOM_OFFSET   = 3'd4,
    REG_WHITE_THRESHOLD = 3'd5
  } cfg_reg_t;

  // q1.15 pair weights, 0.65^k rounded to nearest
  localparam logic [16:0] WEIGHT_Q15 [MAX_PAIRS] = '{
    17'd32768, 17'd21299, 17'd13844, 17'd8999,
    17'd5849,  17'd3802,  17'd2471,  17'd1606
  };

  typedef struct packed {
    logic [7:0] gray_pixel;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic signed [16:0] line_error;
    logic [3:0]         unequal_pairs;
  } result_t;

  typedef struct packed {
    logic [11:0]             frame_width;
    logic [11:0]             frame_height;
    logic signed [POS_W-1:0] band_top;
    logic signed [POS_W-1:0] band_bot;
    logic                    sensor_on;
    logic [SUM_W-1:0]        limit;
  } geom_t;

endpackage

/* src/cle_queue.sv */
module cle_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [WIDTH-1:0]             wdata,
  input  logic                         pop,
  output logic [WIDTH-1:0]             rdata,
  output logic                         full,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

/* src/cle_cfg.sv */
module cle_cfg import cle_pkg::*; #(
  parameter int NUM_PAIRS = 5
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  output logic                    busy,
  output geom_t                   geom,
  output logic signed [POS_W-1:0] bound [2*NUM_PAIRS+1]
);

  localparam int NB     = 2*NUM_PAIRS + 1;
  localparam int BI_W   = $clog2(NB);
  localparam int HALF_W = 10;
  // reciprocal of the pair count, exact for any 10-bit dividend
  localparam int RCP_SH = 20;
  localparam int PROD_W = RCP_SH + HALF_W + 1;
  localparam logic [RCP_SH:0] RCP = (RCP_SH+1)'((2**RCP_SH + NUM_PAIRS - 1) / NUM_PAIRS);

  typedef enum logic [2:0] {
    ST_LOAD, ST_DIV, ST_GEOM, ST_LIMIT, ST_BOUND, ST_DONE
  } state_t;

  state_t                  state;
  logic [11:0]             frame_width;
  logic [11:0]             frame_height;
  logic [10:0]             band_width;
  logic [7:0]              band_height;
  logic [9:0]              bottom_offset;
  logic [7:0]              white_threshold;
  logic [HALF_W-1:0]       dvd;
  logic [HALF_W-1:0]       quo;
  logic [HALF_W-1:0]       sw;
  logic signed [POS_W-1:0] mid;
  logic signed [POS_W-1:0] band_top;
  logic signed [POS_W-1:0] band_bot;
  logic signed [POS_W-1:0] cur;
  logic [CNT_W-1:0]        count;
  logic [SUM_W-1:0]        limit;
  logic                    sensor_on;
  logic [BI_W-1:0]         bidx;

  logic [PROD_W-1:0]       prod;
  logic signed [POS_W-1:0] diff;
  logic signed [POS_W-1:0] start_x;
  logic signed [POS_W-1:0] half_s;
  logic [POS_W-1:0]        psw;
  logic signed [POS_W-1:0] next_bound;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_DONE);

  always_comb begin
    prod       = PROD_W'(dvd) * PROD_W'(RCP);
    diff       = $signed(POS_W'(frame_width)) - $signed(POS_W'(band_width));
    // divide by two, truncating toward zero
    start_x    = (diff + $signed(POS_W'(diff[POS_W-1]))) >>> 1;
    half_s     = $signed(POS_W'(band_width[10:1]));
    psw        = POS_W'(sw) * POS_W'(NUM_PAIRS);
    next_bound = cur + $signed(POS_W'(sw));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_LOAD;
      frame_width     <= 12'd640;
      frame_height    <= 12'd480;
      band_width      <= 11'd400;
      band_height     <= 8'd30;
      bottom_offset   <= 10'd0;
      white_threshold <= 8'd190;
      bidx            <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:     frame_width     <= cfg_data;
        REG_FRAME_HEIGHT:    frame_height    <= cfg_data;
        REG_BAND_WIDTH:      band_width      <= cfg_data[10:0];
        REG_BAND_HEIGHT:     band_height     <= cfg_data[7:0];
        REG_BOTTOM_OFFSET:   bottom_offset   <= cfg_data[9:0];
        REG_WHITE_THRESHOLD: white_threshold <= cfg_data[7:0];
        default: ;
      endcase
      state <= ST_LOAD;
    end else begin
      unique case (state)
        ST_LOAD: begin
          dvd   <= band_width[10:1];
          state <= ST_DIV;
        end
        ST_DIV: begin
          // half band width over the pair count by reciprocal multiply
          quo   <= prod[RCP_SH +: HALF_W];
          state <= ST_GEOM;
        end
        ST_GEOM: begin
          sw        <= quo;
          sensor_on <= (quo != '0);
          mid       <= half_s + start_x;
          band_top  <= $signed(POS_W'(frame_height)) - $signed(POS_W'(band_height))
                       - $signed(POS_W'(bottom_offset));
          count     <= CNT_W'(quo) * CNT_W'(band_height);
          state     <= ST_LIMIT;
        end
        ST_LIMIT: begin
          limit    <= SUM_W'(white_threshold) * SUM_W'(count);
          band_bot <= band_top + $signed(POS_W'(band_height));
          cur      <= mid - $signed(psw);
          bound[0] <= mid - $signed(psw);
          bidx     <= BI_W'(1);
          state    <= ST_BOUND;
        end
        ST_BOUND: begin
          bound[bidx] <= next_bound;
          cur         <= next_bound;
          if (bidx == BI_W'(NB-1)) begin
            state <= ST_DONE;
          end else begin
            bidx <= bidx + 1'b1;
          end
        end
        ST_DONE: ;
        default: state <= ST_LOAD;
      endcase
    end
  end

  always_comb begin
    geom.frame_width  = frame_width;
    geom.frame_height = frame_height;
    geom.band_top     = band_top;
    geom.band_bot     = band_bot;
    geom.sensor_on    = sensor_on;
    geom.limit        = limit;
  end

endmodule

/* src/cle_front.sv */
module cle_front import cle_pkg::*; #(
  parameter int NUM_PAIRS = 5,
  parameter int SQ_DEPTH  = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  in_item_t                    item,
  input  logic                        busy,
  input  geom_t                       geom,
  input  logic signed [POS_W-1:0]     bound [2*NUM_PAIRS+1],
  input  logic [$clog2(SQ_DEPTH+1)-1:0] sq_count,
  output logic                        sq_push,
  output logic [2*NUM_PAIRS-1:0]      sq_data
);

  localparam int NR   = 2*NUM_PAIRS;
  localparam int NB   = NR + 1;
  localparam int SQ_W = $clog2(SQ_DEPTH+1) + 1;

  logic [11:0]      col;
  logic [11:0]      row;
  logic             accept;
  logic [11:0]      xc;
  logic [11:0]      yc;
  logic             line_end;
  logic             frame_end;

  logic             s1_valid;
  logic             s1_start;
  logic             s1_fe;
  logic [7:0]       s1_pix;
  logic [11:0]      s1_x;
  logic [11:0]      s1_y;

  logic             s2_valid;
  logic             s2_start;
  logic             s2_fe;
  logic [7:0]       s2_pix;
  logic [NR-1:0]    s2_hit;

  logic [SUM_W-1:0] sums [NR];
  logic [SUM_W-1:0] nxt [NR];
  logic [NR-1:0]    white;
  logic [NB-1:0]    ge;
  logic [NR-1:0]    hit;
  logic             row_in;
  logic signed [POS_W-1:0] xs;
  logic signed [POS_W-1:0] ys;
  logic [SQ_W-1:0]  pending;

  // frame ends still in the pipe are counted against queue room
  assign pending = SQ_W'(sq_count) + SQ_W'(s1_valid & s1_fe) + SQ_W'(s2_valid & s2_fe);
  assign full    = busy || (pending >= SQ_W'(SQ_DEPTH));
  assign accept  = push && !full;

  always_comb begin
    xc        = item.frame_start ? '0 : col;
    yc        = item.frame_start ? '0 : row;
    line_end  = ({1'b0, xc} + 13'd1) >= {1'b0, geom.frame_width};
    frame_end = line_end && (({1'b0, yc} + 13'd1) >= {1'b0, geom.frame_height});
  end

  always_comb begin
    xs     = $signed(POS_W'(s1_x));
    ys     = $signed(POS_W'(s1_y));
    row_in = (ys >= geom.band_top) && (ys < geom.band_bot);
    for (int k = 0; k < NB; k++) begin
      ge[k] = (xs >= bound[k]);
    end
    // left regions run outward from the centre, right regions likewise
    for (int k = 0; k < NR; k++) begin
      if (k < NUM_PAIRS) begin
        hit[NUM_PAIRS-1-k] = ge[k] && !ge[k+1] && row_in && geom.sensor_on;
      end else begin
        hit[k] = ge[k] && !ge[k+1] && row_in && geom.sensor_on;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NR; i++) begin
      nxt[i]   = (s2_start ? '0 : sums[i]) + (s2_hit[i] ? SUM_W'(s2_pix) : '0);
      white[i] = (nxt[i] > geom.limit);
    end
  end

  assign sq_push = s2_valid && s2_fe;
  assign sq_data = white;

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      for (int i = 0; i < NR; i++) begin
        sums[i] <= '0;
      end
    end else begin
      if (accept) begin
        if (line_end) begin
          col <= '0;
          row <= frame_end ? '0 : yc + 1'b1;
        end else begin
          col <= xc + 1'b1;
          row <= yc;
        end
      end
      s1_valid <= accept;
      s2_valid <= s1_valid;
      if (s2_valid) begin
        for (int i = 0; i < NR; i++) begin
          sums[i] <= s2_fe ? '0 : nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_start <= item.frame_start;
    s1_fe    <= frame_end;
    s1_pix   <= item.gray_pixel;
    s1_x     <= xc;
    s1_y     <= yc;
    s2_start <= s1_start;
    s2_fe    <= s1_fe;
    s2_pix   <= s1_pix;
    s2_hit   <= hit;
  end

endmodule

/* src/cle_back.sv */
module cle_back import cle_pkg::*; #(
  parameter int NUM_PAIRS = 5
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sq_empty,
  output logic                   sq_pop,
  input  logic [2*NUM_PAIRS-1:0] sq_data,
  input  logic                   rq_full,
  output logic                   rq_push,
  output result_t                res
);

  localparam int JW = (NUM_PAIRS > 1) ? $clog2(NUM_PAIRS) : 1;
  localparam int NW = $clog2(NUM_PAIRS+1);
  localparam int DW = $clog2(MAG_W);

  typedef enum logic [2:0] {
    ST_IDLE, ST_ACC, ST_PREP, ST_DIV, ST_FIN, ST_OUT
  } state_t;

  state_t                  state;
  logic [NUM_PAIRS-1:0]    left;
  logic [NUM_PAIRS-1:0]    right;
  logic [JW-1:0]           j;
  logic signed [ACC_W-1:0] acc;
  logic [NW-1:0]           n;
  logic [MAG_W-1:0]        mag;
  logic [MAG_W-1:0]        quo;
  logic [NW-1:0]           rem;
  logic                    neg;
  logic [DW-1:0]           dcnt;

  logic [2:0]              widx;
  logic signed [ACC_W-1:0] wgt;
  logic [NW:0]             trial;

  assign sq_pop  = (state == ST_IDLE) && !sq_empty;
  assign rq_push = (state == ST_OUT) && !rq_full;

  always_comb begin
    widx  = 3'(NUM_PAIRS - 1) - 3'(j);
    wgt   = $signed(ACC_W'(WEIGHT_Q15[widx]));
    trial = {rem, mag[MAG_W-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (!sq_empty) begin
            left  <= sq_data[NUM_PAIRS-1:0];
            right <= sq_data[2*NUM_PAIRS-1:NUM_PAIRS];
            j     <= '0;
            acc   <= '0;
            n     <= '0;
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          // one pair per cycle, right minus left
          if (right[j] && !left[j]) begin
            acc <= acc + wgt;
            n   <= n + 1'b1;
          end else if (left[j] && !right[j]) begin
            acc <= acc - wgt;
            n   <= n + 1'b1;
          end
          if (j == JW'(NUM_PAIRS-1)) begin
            state <= ST_PREP;
          end else begin
            j <= j + 1'b1;
          end
        end
        ST_PREP: begin
          neg  <= acc[ACC_W-1];
          mag  <= MAG_W'(acc[ACC_W-1] ? -acc : acc);
          quo  <= '0;
          rem  <= '0;
          dcnt <= '0;
          if (n == '0) begin
            res.line_error    <= '0;
            res.unequal_pairs <= '0;
            state             <= ST_OUT;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          // restoring division of the magnitude by the unequal count
          if (trial >= {1'b0, n}) begin
            rem <= NW'(trial - {1'b0, n});
            quo <= {quo[MAG_W-2:0], 1'b1};
          end else begin
            rem <= trial[NW-1:0];
            quo <= {quo[MAG_W-2:0], 1'b0};
          end
          mag  <= mag << 1;
          dcnt <= dcnt + 1'b1;
          if (dcnt == DW'(MAG_W-1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          res.line_error    <= neg ? -$signed(quo) : $signed(quo);
          res.unequal_pairs <= 4'(n);
          state             <= ST_OUT;
        end
        ST_OUT: begin
          if (!rq_full) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* src/camera_line_position_error.sv */
// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+-------------------------------
// pixel     | in        | push / full            | in_item_t: gray_pixel, frame_start
// result    | out       | pop / empty            | result_t: line_error, unequal_pairs
// cfg       | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one pixel per cycle is taken while full is low; a pixel transaction passes the
// s1 and s2 registers before it updates its region sums, and the frame's last
// pixel hands the white map to a short queue. the combine unit then takes one
// pair per cycle and, if any pair differs, runs a one-bit-per-cycle divide; it
// pops the next map only after pushing its result, and full is high while the
// summary queue, counting frame ends still in the pipe, has no room.
// after reset and after every register write the geometry sequencer steps through
// load, divide, geometry, limit and bound with full high; cfg_ready is always high.
// a stalled result waits in the output queue, then in the combine unit.
module camera_line_position_error import cle_pkg::*; #(
  parameter int NUM_PAIRS = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  // pixel stream
  input  logic                  push,
  output logic                  full,
  input  in_item_t              pixel,
  // results, one per frame
  output logic                  empty,
  input  logic                  pop,
  output result_t               result,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // summary queue holds the white map of finished frames
  localparam int SQ_DEPTH = 4;
  localparam int RQ_DEPTH = 2;
  localparam int NR       = 2*NUM_PAIRS;
  localparam int RES_W    = $bits(result_t);

  logic                           busy;
  geom_t                          geom;
  logic signed [POS_W-1:0]        bound [NR+1];

  logic                           sq_push;
  logic                           sq_pop;
  logic [NR-1:0]                  sq_wdata;
  logic [NR-1:0]                  sq_rdata;
  logic                           sq_full;
  logic                           sq_empty;
  logic [$clog2(SQ_DEPTH+1)-1:0]  sq_count;

  logic                           rq_push;
  logic                           rq_full;
  logic [$clog2(RQ_DEPTH+1)-1:0]  rq_count;
  result_t                        back_res;
  logic [RES_W-1:0]               rq_rdata;

  // register file and derived band geometry
  cle_cfg #(.NUM_PAIRS(NUM_PAIRS)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .geom      (geom),
    .bound     (bound)
  );

  // front: raster position, region classification and per-region sums
  cle_front #(.NUM_PAIRS(NUM_PAIRS), .SQ_DEPTH(SQ_DEPTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (pixel),
    .busy     (busy),
    .geom     (geom),
    .bound    (bound),
    .sq_count (sq_count),
    .sq_push  (sq_push),
    .sq_data  (sq_wdata)
  );

  // front never pushes without room, reserved through sq_count
  cle_queue #(.WIDTH(NR), .DEPTH(SQ_DEPTH)) u_sq (
    .clk   (clk),
    .rst   (rst),
    .push  (sq_push),
    .wdata (sq_wdata),
    .pop   (sq_pop),
    .rdata (sq_rdata),
    .full  (sq_full),
    .empty (sq_empty),
    .count (sq_count)
  );

  // back: weighted pair sum and division
  cle_back #(.NUM_PAIRS(NUM_PAIRS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .sq_empty (sq_empty),
    .sq_pop   (sq_pop),
    .sq_data  (sq_rdata),
    .rq_full  (rq_full),
    .rq_push  (rq_push),
    .res      (back_res)
  );

  // output queue decouples the result consumer
  cle_queue #(.WIDTH(RES_W), .DEPTH(RQ_DEPTH)) u_rq (
    .clk   (clk),
    .rst   (rst),
    .push  (rq_push),
    .wdata (back_res),
    .pop   (pop),
    .rdata (rq_rdata),
    .full  (rq_full),
    .empty (empty),
    .count (rq_count)
  );

  assign result = result_t'(rq_rdata);

  // queue flags not otherwise used, folded into one unused signal
  logic unused_levels;
  assign unused_levels = sq_full ^ (rq_count == '0);

endmodule

/* dv/tb_camera_line_position_error.sv */
`timescale 1ns / 100ps

module tb_camera_line_position_error;
  import cle_pkg::*;

  localparam int NUM_PAIRS   = 5;
  // combine unit, divider and output queue all drained
  localparam int SETTLE_CYC  = 4 * NUM_PAIRS + 60;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PCT    = 33;
  localparam int NUM_PHASES  = 14;
  localparam int PHASE_ITEMS = 30;
  // index past the register map, must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // q1.15 weights by distance from the outermost pair, 0.65^k
  localparam int PAIR_WEIGHT [8] = '{32768, 21299, 13844, 8999, 5849, 3802, 2471, 1606};

  typedef struct {
    int frame_w;
    int frame_h;
    int band_w;
    int band_h;
    int bottom;
    int thresh;
  } sensing_cfg_t;

  // one pixel transaction of the directed table, with an optional hand-typed result
  typedef struct packed {
    in_item_t item;
    logic     typed;
    result_t  want;
  } stim_row_t;

  localparam result_t NO_RES = '0;

  // directed frames use a 10x1 frame, band of 10x1, one pixel per region, threshold 128
  localparam stim_row_t DIRECTED_ROWS [23] = '{
    // partial frame of white pixels, thrown away by the next frame start
    '{'{8'd255, 1'b1}, 1'b0, NO_RES},
    '{'{8'd255, 1'b0}, 1'b0, NO_RES},
    '{'{8'd255, 1'b0}, 1'b0, NO_RES},
    // only the outermost right region white; pixels equal to threshold stay black
    '{'{8'd0,   1'b1}, 1'b0, NO_RES},
    '{'{8'd0,   1'b0}, 1'b0, NO_RES},
    '{'{8'd0,   1'b0}, 1'b0, NO_RES},
    '{'{8'd0,   1'b0}, 1'b0, NO_RES},
    '{'{8'd128, 1'b0}, 1'b0, NO_RES},
    '{'{8'd128, 1'b0}, 1'b0, NO_RES},
    '{'{8'd0,   1'b0}, 1'b0, NO_RES},
    '{'{8'd0,   1'b0}, 1'b0, NO_RES},
    '{'{8'd0,   1'b0}, 1'b0, NO_RES},
    '{'{8'd255, 1'b0}, 1'b1, '{17'sd32768, 4'd1}},
    // whole left half white, right half black: every pair differs
    '{'{8'd255, 1'b1}, 1'b0, NO_RES},
    '{'{8'd255, 1'b0}, 1'b0, NO_RES},
    '{'{8'd255, 1'b0}, 1'b0, NO_RES},
    '{'{8'd255, 1'b0}, 1'b0, NO_RES},
    '{'{8'd255, 1'b0}, 1'b0, NO_RES},
    '{'{8'd0,   1'b0}, 1'b0, NO_RES},
    '{'{8'd0,   1'b0}, 1'b0, NO_RES},
    '{'{8'd0,   1'b0}, 1'b0, NO_RES},
    '{'{8'd0,   1'b0}, 1'b0, NO_RES},
    '{'{8'd0,   1'b0}, 1'b1, '{-17'sd16551, 4'd5}}
  };

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  push      = 1'b0;
  logic                  full;
  in_item_t              pixel     = '0;
  logic                  empty;
  logic                  pop       = 1'b0;
  result_t               result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // line tracker copy: registers, raster position and region sums
  sensing_cfg_t     live_cfg;
  int               col_q;
  int               row_q;
  longint unsigned  region_sum [2*NUM_PAIRS];

  result_t          frame_results_due [$];
  int               mismatch_count  = 0;
  int               cycle_count     = 0;
  bit               no_idle_stretch = 1'b0;

  camera_line_position_error #(.NUM_PAIRS(NUM_PAIRS)) i_dut (
    .clk,
    .rst,
    .push,
    .full,
    .pixel,
    .empty,
    .pop,
    .result,
    .cfg_valid,
    .cfg_ready,
    .cfg_index,
    .cfg_data
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case a handshake never completes
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // advance the line tracker by one pixel; returns 1 when the pixel closes a frame
  function automatic bit line_error_after_pixel(in_item_t it, output result_t res);
    int              sensor_w;
    int              start_x;
    int              mid;
    int              area_y;
    int              off;
    int              idx;
    int              acc;
    int              n;
    int              l;
    int              r;
    int              err;
    int              j;
    longint unsigned lim;
    bit              line_end;
    bit              frame_end;
    sensor_w = live_cfg.band_w / 2 / NUM_PAIRS;
    start_x  = (live_cfg.frame_w - live_cfg.band_w) / 2;
    mid      = live_cfg.band_w / 2 + start_x;
    area_y   = live_cfg.frame_h - live_cfg.band_h - live_cfg.bottom;
    res      = '0;
    // frame start marker drops any partial frame before this pixel counts
    if (it.frame_start) begin
      col_q = 0;
      row_q = 0;
      foreach (region_sum[i]) region_sum[i] = 0;
    end
    // band may hang off the frame on any side; only pixels inside it count
    if (sensor_w > 0 && row_q >= area_y && row_q < area_y + live_cfg.band_h &&
        col_q >= mid - NUM_PAIRS * sensor_w && col_q < mid + NUM_PAIRS * sensor_w) begin
      off = col_q - mid;
      idx = (off >= 0) ? NUM_PAIRS + off / sensor_w : (-off - 1) / sensor_w;
      if (idx < 2 * NUM_PAIRS) region_sum[idx] += it.gray_pixel;
    end
    // zero width or height acts like one
    line_end  = (col_q + 1 >= live_cfg.frame_w);
    frame_end = line_end && (row_q + 1 >= live_cfg.frame_h);
    if (line_end) begin
      col_q = 0;
      row_q = frame_end ? 0 : (row_q + 1) % 4096;
    end else begin
      col_q = (col_q + 1) % 4096;
    end
    if (!frame_end) return 1'b0;
    // white test against the nominal region size, not the pixels actually seen
    lim = longint'(live_cfg.thresh) * sensor_w * live_cfg.band_h;
    acc = 0;
    n   = 0;
    for (j = 0; j < NUM_PAIRS; j++) begin
      l = (region_sum[j] > lim);
      r = (region_sum[NUM_PAIRS + j] > lim);
      if (r != l) n++;
      acc += (r - l) * PAIR_WEIGHT[NUM_PAIRS - 1 - j];
    end
    // signed divide truncates toward zero
    err = (n != 0) ? acc / n : 0;
    res.line_error    = err[16:0];
    res.unequal_pairs = n[3:0];
    foreach (region_sum[i]) region_sum[i] = 0;
    return 1'b1;
  endfunction

  // one pixel transaction with random idle cycles ahead of it
  task automatic send_pixel(in_item_t it, bit typed, result_t want);
    result_t res;
    bit      produced;
    while (!no_idle_stretch && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push  <= 1'b1;
    pixel <= it;
    do @(posedge clk); while (full);
    produced = line_error_after_pixel(it, res);
    if (typed) frame_results_due.insert(frame_results_due.size(), want);
    else if (produced) frame_results_due.insert(frame_results_due.size(), res);
  endtask

  // stop the pixel stream, drain every result, then let the pipeline empty out
  task automatic wait_idle();
    push <= 1'b0;
    while (frame_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // valid stays high across back-to-back register writes
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FRAME_WIDTH:     live_cfg.frame_w = data;
      REG_FRAME_HEIGHT:    live_cfg.frame_h = data;
      REG_BAND_WIDTH:      live_cfg.band_w  = data[10:0];
      REG_BAND_HEIGHT:     live_cfg.band_h  = data[7:0];
      REG_BOTTOM_OFFSET:   live_cfg.bottom  = data[9:0];
      REG_WHITE_THRESHOLD: live_cfg.thresh  = data[7:0];
      default: ;
    endcase
  endtask

  // junk above each register's width must be dropped
  task automatic apply_config(sensing_cfg_t c, bit poke_unused);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 12'(c.frame_w));
    write_reg(REG_FRAME_HEIGHT, 12'(c.frame_h));
    write_reg(REG_BAND_WIDTH, {1'($urandom), 11'(c.band_w)});
    write_reg(REG_BAND_HEIGHT, {4'($urandom), 8'(c.band_h)});
    write_reg(REG_BOTTOM_OFFSET, {2'($urandom), 10'(c.bottom)});
    write_reg(REG_WHITE_THRESHOLD, {4'($urandom), 8'(c.thresh)});
    if (poke_unused) write_reg(REG_UNUSED, 12'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // mostly whole frames with blocky bright/dark content, some cut short or unmarked
  task automatic run_frames(int budget, int min_frames);
    int          sent;
    int          frames;
    int          frame_len;
    int          cut;
    int          sensor_w;
    int          col;
    int          p;
    logic [15:0] bright;
    in_item_t    it;
    sent   = 0;
    frames = 0;
    while (sent < budget || frames < min_frames) begin
      frame_len = ((live_cfg.frame_w == 0) ? 1 : live_cfg.frame_w) *
                  ((live_cfg.frame_h == 0) ? 1 : live_cfg.frame_h);
      cut      = ($urandom_range(99) < 5) ? $urandom_range(1, frame_len) : frame_len;
      bright   = $urandom;
      sensor_w = live_cfg.band_w / 2 / NUM_PAIRS;
      if (sensor_w == 0) sensor_w = 1;
      for (p = 0; p < cut; p++) begin
        it.frame_start = (p == 0) ? ($urandom_range(99) < 90) : ($urandom_range(999) == 0);
        col = it.frame_start ? 0 : col_q;
        if ($urandom_range(99) < 10) begin
          it.gray_pixel = $urandom;
        end else if (bright[(col / sensor_w) % 16]) begin
          it.gray_pixel = $urandom_range(255, (live_cfg.thresh == 255) ? 255 :
                                              live_cfg.thresh + 1);
        end else begin
          it.gray_pixel = $urandom_range(live_cfg.thresh, 0);
        end
        send_pixel(it, 1'b0, NO_RES);
      end
      sent += cut;
      frames++;
      // now and then hold the stream until every frame result is out
      if (frame_results_due.size() != 0 && $urandom_range(9) == 0) begin
        push <= 1'b0;
        do @(posedge clk); while (frame_results_due.size() != 0);
      end
    end
  endtask

  task automatic check_frame_result(result_t got);
    result_t want;
    if (frame_results_due.size() == 0) begin
      report_mismatch($sformatf("result with none due: line_error %0d unequal_pairs %0d",
                                got.line_error, got.unequal_pairs));
      return;
    end
    want = frame_results_due.pop_front();
    if (got.line_error !== want.line_error) begin
      report_mismatch($sformatf("line_error %0d, want %0d", got.line_error, want.line_error));
    end
    if (got.unequal_pairs !== want.unequal_pairs) begin
      report_mismatch($sformatf("unequal_pairs %0d, want %0d",
                                got.unequal_pairs, want.unequal_pairs));
    end
  endtask

  // result side: sample the pre-edge values, pop with a chance of about 67 percent unless idle stretches are off
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_frame_result(result);
      pop <= no_idle_stretch || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    sensing_cfg_t c;
    int           ph;
    int           budget;
    int           min_frames;
    // register defaults and cleared raster state
    live_cfg = '{640, 480, 400, 30, 0, 190};
    col_q    = 0;
    row_q    = 0;
    foreach (region_sum[i]) region_sum[i] = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed frames, one pixel per region
    c = '{10, 1, 10, 1, 0, 128};
    apply_config(c, 1'b0);
    foreach (DIRECTED_ROWS[i]) begin
      send_pixel(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    end

    // random phases, each under a new register setting
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      c.frame_w  = $urandom_range(1, 24);
      c.frame_h  = $urandom_range(1, 3);
      c.band_w   = $urandom_range(10, 2 * c.frame_w + 20);
      c.band_h   = $urandom_range(1, c.frame_h + 1);
      c.bottom   = $urandom_range(0, 2);
      c.thresh   = $urandom_range(0, 255);
      budget     = PHASE_ITEMS;
      min_frames = 3;
      case (ph)
        1: c.thresh = 0;
        // a mean of 255 is never above 255, all black
        2: c.thresh = 255;
        // sensors of zero width
        3: c.band_w = $urandom_range(0, 9);
        // band much wider and taller than the frame, widest nominal count
        4: begin
          c.band_w = 2047;
          c.band_h = 255;
          c.thresh = $urandom_range(0, 3);
        end
        // band lifted above the top of the frame
        5: c.bottom = 1023;
        // zero sizes: every pixel closes a frame
        6: begin
          c.frame_w = 0;
          c.frame_h = 0;
        end
        // one long line under the widest band, single frame
        7: begin
          c.frame_w  = 64;
          c.frame_h  = 1;
          c.band_w   = 2047;
          c.band_h   = 1;
          c.bottom   = 0;
          budget     = 1;
          min_frames = 1;
        end
        // one tall column under the tallest band, single frame
        8: begin
          c.frame_w  = 1;
          c.frame_h  = 64;
          c.band_w   = 10;
          c.band_h   = 255;
          c.bottom   = 0;
          budget     = 1;
          min_frames = 1;
        end
        9: budget = 4 * PHASE_ITEMS;
        // zero band height, nothing is summed
        10: c.band_h = 0;
        default: ;
      endcase
      apply_config(c, ph == 5);
      no_idle_stretch = (ph == 9);
      run_frames(budget, min_frames);
      no_idle_stretch = 1'b0;
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
